@@ rtl/core/oadc_pkg.sv @@
// shared types and constants of the obstacle avoid drive controller
package oadc_pkg;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int SPEED_W = 11;
  localparam int RAW_W   = 10;
  localparam int MAG_W   = 9;
  localparam int PCT_W   = 7;
  localparam int PROD_W  = 16;

  localparam logic [7:0] FULL_SPEED     = 8'd255;
  localparam logic [7:0] BRAKE_DISTANCE = 8'd200;
  localparam logic [7:0] TURN_DIST_FULL = 8'd255;

  localparam logic [7:0] SQUELCH_LEVEL_RST    = 8'd5;
  localparam logic [7:0] TURN_DISTANCE_RST    = 8'd25;
  localparam logic [6:0] MIN_SPEED_PCT_RST    = 7'd25;
  localparam logic       WALL_ENABLE_RST      = 1'b0;
  localparam logic [7:0] WALL_ENTER_LEVEL_RST = 8'd80;
  localparam logic [7:0] WALL_NEAR_LEVEL_RST  = 8'd20;
  localparam logic [7:0] WALL_TRIM_RST        = 8'd40;
  localparam logic [5:0] START_OFFSET_RST     = 6'd10;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_AVOID = 2'd1,
    MODE_WALL  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_SQUELCH_LEVEL    = 3'd0,
    REG_TURN_DISTANCE    = 3'd1,
    REG_MIN_SPEED_PCT    = 3'd2,
    REG_WALL_ENABLE      = 3'd3,
    REG_WALL_ENTER_LEVEL = 3'd4,
    REG_WALL_NEAR_LEVEL  = 3'd5,
    REG_WALL_TRIM        = 3'd6,
    REG_START_OFFSET     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] squelch_level;
    logic [7:0] turn_distance;
    logic [6:0] min_speed_pct;
    logic       wall_enable;
    logic [7:0] wall_enter_level;
    logic [7:0] wall_near_level;
    logic [7:0] wall_trim;
    logic       offset_load;
    logic [5:0] offset_value;
  } cfg_t;

  typedef struct packed {
    logic       start_pressed;
    logic [7:0] front_distance;
    logic [7:0] ir_front_left;
    logic [7:0] ir_front_right;
    logic [7:0] ir_back_left;
  } sample_t;

  typedef struct packed {
    logic [PROD_W-1:0] left_prod;
    logic [PROD_W-1:0] right_prod;
    logic              left_cw;
    logic              right_cw;
    logic              aux_led;
    mode_t             mode_now;
  } stage_t;

endpackage

@@ rtl/core/oadc_if.sv @@
// valid/ready channels for sensor words and drive words
interface oadc_sensor_if;
  logic       valid;
  logic       ready;
  logic       start_pressed;
  logic [7:0] front_distance;
  logic [7:0] ir_front_left;
  logic [7:0] ir_front_right;
  logic [7:0] ir_back_left;

  modport source (
    output valid, start_pressed, front_distance, ir_front_left, ir_front_right,
           ir_back_left,
    input  ready
  );
  modport sink (
    input  valid, start_pressed, front_distance, ir_front_left, ir_front_right,
           ir_back_left,
    output ready
  );
endinterface

interface oadc_drive_if;
  logic                         valid;
  logic                         ready;
  logic [oadc_pkg::SPEED_W-1:0] left_speed;
  logic [oadc_pkg::SPEED_W-1:0] right_speed;
  logic                         left_cw;
  logic                         right_cw;
  logic                         aux_led;
  logic [1:0]                   mode_now;

  modport source (
    output valid, left_speed, right_speed, left_cw, right_cw, aux_led, mode_now,
    input  ready
  );
  modport sink (
    input  valid, left_speed, right_speed, left_cw, right_cw, aux_led, mode_now,
    output ready
  );
endinterface

@@ rtl/core/oadc_regs.sv @@
// configuration register file behind the apb port
module oadc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [oadc_pkg::ADDR_W-1:0] paddr,
  input  logic [oadc_pkg::DATA_W-1:0] pwdata,
  output logic [oadc_pkg::DATA_W-1:0] prdata,
  output oadc_pkg::cfg_t              cfg
);

  logic [7:0] squelch_level;
  logic [7:0] turn_distance;
  logic [6:0] min_speed_pct;
  logic       wall_enable;
  logic [7:0] wall_enter_level;
  logic [7:0] wall_near_level;
  logic [7:0] wall_trim;
  logic [5:0] start_offset;

  logic                 wr;
  oadc_pkg::reg_idx_t   idx;

  assign wr  = psel && penable && pwrite;
  assign idx = oadc_pkg::reg_idx_t'(paddr[oadc_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      squelch_level    <= oadc_pkg::SQUELCH_LEVEL_RST;
      turn_distance    <= oadc_pkg::TURN_DISTANCE_RST;
      min_speed_pct    <= oadc_pkg::MIN_SPEED_PCT_RST;
      wall_enable      <= oadc_pkg::WALL_ENABLE_RST;
      wall_enter_level <= oadc_pkg::WALL_ENTER_LEVEL_RST;
      wall_near_level  <= oadc_pkg::WALL_NEAR_LEVEL_RST;
      wall_trim        <= oadc_pkg::WALL_TRIM_RST;
      start_offset     <= oadc_pkg::START_OFFSET_RST;
    end else if (wr) begin
      case (idx)
        oadc_pkg::REG_SQUELCH_LEVEL:    squelch_level    <= pwdata[7:0];
        oadc_pkg::REG_TURN_DISTANCE:    turn_distance    <= pwdata[7:0];
        oadc_pkg::REG_MIN_SPEED_PCT:    min_speed_pct    <= pwdata[6:0];
        oadc_pkg::REG_WALL_ENABLE:      wall_enable      <= pwdata[0];
        oadc_pkg::REG_WALL_ENTER_LEVEL: wall_enter_level <= pwdata[7:0];
        oadc_pkg::REG_WALL_NEAR_LEVEL:  wall_near_level  <= pwdata[7:0];
        oadc_pkg::REG_WALL_TRIM:        wall_trim        <= pwdata[7:0];
        oadc_pkg::REG_START_OFFSET:     start_offset     <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      oadc_pkg::REG_SQUELCH_LEVEL:    prdata = 32'(squelch_level);
      oadc_pkg::REG_TURN_DISTANCE:    prdata = 32'(turn_distance);
      oadc_pkg::REG_MIN_SPEED_PCT:    prdata = 32'(min_speed_pct);
      oadc_pkg::REG_WALL_ENABLE:      prdata = 32'(wall_enable);
      oadc_pkg::REG_WALL_ENTER_LEVEL: prdata = 32'(wall_enter_level);
      oadc_pkg::REG_WALL_NEAR_LEVEL:  prdata = 32'(wall_near_level);
      oadc_pkg::REG_WALL_TRIM:        prdata = 32'(wall_trim);
      oadc_pkg::REG_START_OFFSET:     prdata = 32'(start_offset);
      default:                        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.squelch_level    = squelch_level;
    cfg.turn_distance    = turn_distance;
    cfg.min_speed_pct    = min_speed_pct;
    cfg.wall_enable      = wall_enable;
    cfg.wall_enter_level = wall_enter_level;
    cfg.wall_near_level  = wall_near_level;
    cfg.wall_trim        = wall_trim;
    // side offset reloads in the same edge as the register write
    cfg.offset_load      = wr && (idx == oadc_pkg::REG_START_OFFSET);
    cfg.offset_value     = pwdata[5:0];
  end

endmodule

@@ rtl/core/oadc_core.sv @@
// input register, mode machine, raw speeds, percentage scaling and products
module oadc_core (
  input  logic             clk,
  input  logic             rst,
  input  oadc_pkg::cfg_t   cfg,
  oadc_sensor_if.sink      sensor,
  output oadc_pkg::stage_t s2,
  output logic             s2_valid,
  input  logic             s2_ready
);

  oadc_pkg::sample_t s1;
  logic              v1;
  logic              r1;
  logic              r2;
  logic              adv;

  oadc_pkg::mode_t   mode;
  oadc_pkg::mode_t   mode_eff;
  oadc_pkg::mode_t   mode_next;
  logic signed [7:0] side_offset;
  logic signed [7:0] side_offset_next;
  logic              left_dir;
  logic              left_dir_next;
  logic              right_dir;
  logic              right_dir_next;
  logic              led_held;
  logic              led_held_next;

  logic [7:0]                     fl;
  logic [7:0]                     fr;
  logic [7:0]                     bl;
  logic signed [oadc_pkg::RAW_W-1:0] raw_l;
  logic signed [oadc_pkg::RAW_W-1:0] raw_r;
  logic signed [oadc_pkg::RAW_W-1:0] off_ext;
  logic signed [oadc_pkg::RAW_W-1:0] trim_speed;
  logic [oadc_pkg::MAG_W-1:0]     mag_l;
  logic [oadc_pkg::MAG_W-1:0]     mag_r;
  logic [7:0]                     gap_dist;
  logic [oadc_pkg::PCT_W-1:0]     pct;
  oadc_pkg::stage_t               s2_next;

  function automatic logic [7:0] squelch(input logic [7:0] x, input logic [7:0] level);
    squelch = (x < level) ? 8'd0 : x;
  endfunction

  function automatic logic signed [oadc_pkg::RAW_W-1:0] RAW_W_EXT(
      input logic signed [7:0] v);
    RAW_W_EXT = {{(oadc_pkg::RAW_W-8){v[7]}}, v};
  endfunction

  assign r2           = !s2_valid || s2_ready;
  assign r1           = !v1 || r2;
  assign adv          = v1 && r2;
  assign sensor.ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && sensor.valid) begin
      s1.start_pressed  <= sensor.start_pressed;
      s1.front_distance <= sensor.front_distance;
      s1.ir_front_left  <= sensor.ir_front_left;
      s1.ir_front_right <= sensor.ir_front_right;
      s1.ir_back_left   <= sensor.ir_back_left;
    end
  end

  assign fl       = squelch(s1.ir_front_left, cfg.squelch_level);
  assign fr       = squelch(s1.ir_front_right, cfg.squelch_level);
  assign bl       = squelch(s1.ir_back_left, cfg.squelch_level);
  assign mode_eff = s1.start_pressed ? oadc_pkg::MODE_AVOID : mode;
  assign off_ext  = RAW_W_EXT(side_offset);
  assign trim_speed = $signed({2'b00, oadc_pkg::FULL_SPEED - cfg.wall_trim});

  // next mode and side offset
  always_comb begin
    mode_next        = mode_eff;
    side_offset_next = side_offset;
    case (mode_eff)
      oadc_pkg::MODE_AVOID: begin
        if (cfg.wall_enable && (bl > cfg.wall_enter_level)) begin
          mode_next = oadc_pkg::MODE_WALL;
        end
      end
      oadc_pkg::MODE_WALL: begin
        // wall lost: back to avoid and turn the other way
        if (fl == 8'd0) begin
          mode_next        = oadc_pkg::MODE_AVOID;
          side_offset_next = -side_offset;
        end
      end
      default: ;
    endcase
  end

  // raw speeds, directions and led for the current mode
  always_comb begin
    raw_l          = '0;
    raw_r          = '0;
    left_dir_next  = left_dir;
    right_dir_next = right_dir;
    led_held_next  = led_held;
    case (mode_eff)
      oadc_pkg::MODE_AVOID: begin
        led_held_next = 1'b0;
        if (fr < cfg.turn_distance) begin
          left_dir_next = 1'b0;
          raw_l         = $signed({2'b00, oadc_pkg::FULL_SPEED});
        end else begin
          left_dir_next = 1'b1;
          raw_l         = $signed({2'b00, fr});
        end
        if (fl < cfg.turn_distance) begin
          right_dir_next = 1'b1;
          raw_r          = $signed({2'b00, oadc_pkg::FULL_SPEED});
        end else begin
          right_dir_next = 1'b0;
          raw_r          = $signed({2'b00, fl});
        end
        if (side_offset > 8'sd0) begin
          raw_r = raw_r - off_ext;
        end else begin
          raw_l = raw_l - off_ext;
        end
      end
      oadc_pkg::MODE_WALL: begin
        led_held_next  = 1'b1;
        left_dir_next  = 1'b0;
        right_dir_next = 1'b1;
        if (fl < cfg.wall_near_level) begin
          raw_l = trim_speed;
          raw_r = $signed({2'b00, oadc_pkg::FULL_SPEED});
        end else begin
          raw_l = $signed({2'b00, oadc_pkg::FULL_SPEED});
          raw_r = trim_speed;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mag_l = raw_l[oadc_pkg::RAW_W-1] ? '0 : raw_l[oadc_pkg::MAG_W-1:0];
    mag_r = raw_r[oadc_pkg::RAW_W-1] ? '0 : raw_r[oadc_pkg::MAG_W-1:0];
    // spinning on the spot gets the full turn distance
    if (left_dir_next && !right_dir_next) begin
      gap_dist = oadc_pkg::TURN_DIST_FULL;
    end else if (s1.front_distance < oadc_pkg::BRAKE_DISTANCE) begin
      gap_dist = oadc_pkg::BRAKE_DISTANCE - s1.front_distance;
    end else begin
      gap_dist = 8'd0;
    end
    // 100 * d / 200 is d / 2
    pct = gap_dist[7:1];
    if (pct < cfg.min_speed_pct) begin
      pct = cfg.min_speed_pct;
    end
    s2_next.left_prod  = oadc_pkg::PROD_W'(mag_l) * oadc_pkg::PROD_W'(pct);
    s2_next.right_prod = oadc_pkg::PROD_W'(mag_r) * oadc_pkg::PROD_W'(pct);
    s2_next.left_cw    = left_dir_next;
    s2_next.right_cw   = right_dir_next;
    s2_next.aux_led    = led_held_next;
    s2_next.mode_now   = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (r2) begin
      s2_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= s2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= oadc_pkg::MODE_STOP;
      side_offset <= $signed({2'b00, oadc_pkg::START_OFFSET_RST});
      left_dir    <= 1'b0;
      right_dir   <= 1'b0;
      led_held    <= 1'b0;
    end else begin
      if (cfg.offset_load) begin
        side_offset <= $signed({2'b00, cfg.offset_value});
      end else if (adv) begin
        side_offset <= side_offset_next;
      end
      if (adv) begin
        mode      <= mode_next;
        left_dir  <= left_dir_next;
        right_dir <= right_dir_next;
        led_held  <= led_held_next;
      end
    end
  end

`ifndef SYNTH
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_ready |=> s2_valid && $stable(s2))
    else $error("stage two word changed while stalled");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    (side_offset <= 8'sd63) && (side_offset >= -8'sd63))
    else $error("side offset out of range");

  a_wall_outputs: assert property (@(posedge clk) disable iff (rst)
    adv && (mode_eff == oadc_pkg::MODE_WALL) |=> led_held && !left_dir && right_dir)
    else $error("wall follow did not set led and directions");

  a_avoid_stays: assert property (@(posedge clk) disable iff (rst)
    adv && (mode_eff == oadc_pkg::MODE_AVOID) && !cfg.wall_enable
      |=> mode == oadc_pkg::MODE_AVOID)
    else $error("avoid mode left with wall follow disabled");
`endif

endmodule

@@ rtl/core/oadc_out.sv @@
// divide by 25 through a reciprocal and hold the drive word
module oadc_out (
  input  logic             clk,
  input  logic             rst,
  input  oadc_pkg::stage_t s2,
  input  logic             s2_valid,
  output logic             s2_ready,
  oadc_drive_if.source     drive
);

  // 4 * raw * pct / 100 is (raw * pct) / 25
  localparam int unsigned SPEED_DIV = 25;
  localparam int unsigned DIV_SHIFT = 21;
  localparam int unsigned DIV_MUL   = (2**DIV_SHIFT + SPEED_DIV - 1) / SPEED_DIV;
  localparam int          Q_W       = oadc_pkg::PROD_W + 17;

  logic [Q_W-1:0]                left_q;
  logic [Q_W-1:0]                right_q;
  logic                          valid;
  logic [oadc_pkg::SPEED_W-1:0]  left_speed;
  logic [oadc_pkg::SPEED_W-1:0]  right_speed;
  logic                          left_cw;
  logic                          right_cw;
  logic                          aux_led;
  oadc_pkg::mode_t               mode_now;

  assign s2_ready = !valid || drive.ready;
  assign left_q   = Q_W'(s2.left_prod) * Q_W'(DIV_MUL);
  assign right_q  = Q_W'(s2.right_prod) * Q_W'(DIV_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s2_ready) begin
      valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      left_speed  <= left_q[DIV_SHIFT +: oadc_pkg::SPEED_W];
      right_speed <= right_q[DIV_SHIFT +: oadc_pkg::SPEED_W];
      left_cw     <= s2.left_cw;
      right_cw    <= s2.right_cw;
      aux_led     <= s2.aux_led;
      mode_now    <= s2.mode_now;
    end
  end

  assign drive.valid       = valid;
  assign drive.left_speed  = left_speed;
  assign drive.right_speed = right_speed;
  assign drive.left_cw     = left_cw;
  assign drive.right_cw    = right_cw;
  assign drive.aux_led     = aux_led;
  assign drive.mode_now    = mode_now;

endmodule

@@ rtl/core/obstacle_avoid_drive_controller_unit.sv @@
// top level of the obstacle avoid drive controller
// usage:
//   sensor carries one word of samples (start flag, front distance, three ir
//   proximities); drive returns one word per sample: two wheel speeds, wheel
//   directions, the aux led and the mode after the step.
//   the apb port holds eight registers at byte addresses 0, 4 .. 28; pready
//   is tied high and writes land on the access cycle. write registers only
//   while no word is in flight.
// timing:
//   three register stages (input, product, output), each word passing in
//   that order to drive. one word per cycle sustained while drive is ready;
//   the mode, side offset and direction state closes its loop from the
//   input register to the product register.
// reset:
//   registers go to their defaults, mode is stopped, side offset is plus the
//   default start offset, directions and led clear, pipeline empties.
// stall:
//   each stage holds while the next is full; with drive stalled up to three
//   words are held before sensor.ready drops.
module obstacle_avoid_drive_controller_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [oadc_pkg::ADDR_W-1:0] paddr,
  input  logic [oadc_pkg::DATA_W-1:0] pwdata,
  output logic [oadc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  oadc_sensor_if.sink                 sensor,
  oadc_drive_if.source                drive
);

  oadc_pkg::cfg_t   cfg;
  oadc_pkg::stage_t s2;
  logic             s2_valid;
  logic             s2_ready;

  assign pready = 1'b1;

  oadc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  oadc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .sensor   (sensor),
    .s2       (s2),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready)
  );

  oadc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .s2       (s2),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .drive    (drive)
  );

endmodule
